[rtl/core/rbe_pkg.sv]
package rbe_pkg;

    // data types
    typedef logic signed [31:0] q_t;
    typedef logic [16:0]        dt_t;
    typedef logic [30:0]        minv_t;
    typedef logic [5:0]         addr_t;
    typedef logic signed [65:0] acc_t;
    typedef logic [4:0]         cnt_t;

    localparam int PAW    = 5;
    localparam int INIT_N = 18;
    localparam int LOAD_N = 14;
    localparam int OUT_N  = 12;

    localparam q_t   QONE     = 32'sd65536;
    localparam acc_t ACC_QMAX = 66'sd2147483647;
    localparam acc_t ACC_QMIN = -66'sd2147483648;
    localparam acc_t ACC_HALF = 66'sd32768;

    // scratch memory map
    localparam addr_t A_R    = 6'd0;
    localparam addr_t A_L    = 6'd9;
    localparam addr_t A_P    = 6'd12;
    localparam addr_t A_X    = 6'd15;
    localparam addr_t A_F    = 6'd18;
    localparam addr_t A_TQ   = 6'd21;
    localparam addr_t A_DT   = 6'd24;
    localparam addr_t A_IB   = 6'd25;
    localparam addr_t A_MINV = 6'd31;
    localparam addr_t A_TMP  = 6'd32;
    localparam addr_t A_IINV = 6'd41;
    localparam addr_t A_W    = 6'd50;
    localparam addr_t A_NW   = 6'd53;
    localparam addr_t A_VEL  = 6'd56;
    localparam addr_t A_T3   = 6'd59;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IXX, CFG_IYY, CFG_IZZ, CFG_IXY, CFG_IXZ, CFG_IYZ, CFG_MINV
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_LOAD, ST_RD, ST_EX, ST_AC, ST_ROOT, ST_DIV, ST_WAIT, ST_UNLD
    } st_t;

    typedef enum logic [1:0] {
        NS_IDLE, NS_ROOT, NS_DIV
    } nrm_st_t;

    typedef enum logic [2:0] {
        UK_MAC, UK_MSB, UK_ADD, UK_SUB, UK_SQR, UK_ROOT, UK_DIV
    } uop_kind_t;

    typedef enum logic [4:0] {
        PH_TMP, PH_IINV, PH_W, PH_NW, PH_VEL, PH_UPD, PH_D, PH_RUP,
        PH_SQ_A, PH_RT_A, PH_DV_A, PH_CR_A,
        PH_SQ_B, PH_RT_B, PH_DV_B, PH_CR_B,
        PH_SQ_C, PH_RT_C, PH_DV_C
    } phase_t;

    typedef struct packed {
        uop_kind_t kind;
        addr_t     ra;
        addr_t     rb;
        addr_t     dst;
    } uop_t;

    typedef struct packed {
        logic [1:0] ni;
        logic [1:0] nj;
        logic [1:0] nk;
    } lim_t;

    typedef struct packed {
        logic root_go;
        logic div_go;
    } nrm_req_t;

    typedef struct packed {
        logic done;
        q_t   value;
    } nrm_sts_t;

    function automatic logic [1:0] mod3p1(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    function automatic logic [1:0] mod3p2(input logic [1:0] x);
        return (x == 2'd0) ? 2'd2 : x - 2'd1;
    endfunction

    function automatic addr_t ix3(input logic [1:0] r, input logic [1:0] c);
        return addr_t'({r, 1'b0}) + addr_t'(r) + addr_t'(c);
    endfunction

    // symmetric body inverse inertia, six stored entries
    function automatic addr_t ib_addr(input logic [1:0] r, input logic [1:0] c);
        if (r == c)
            return A_IB + addr_t'(r);
        return A_IB + 6'd2 + addr_t'(r) + addr_t'(c);
    endfunction

    function automatic acc_t sext_q(input q_t v);
        return acc_t'(v);
    endfunction

    function automatic q_t sat32(input acc_t v);
        if (v > ACC_QMAX)
            return q_t'(ACC_QMAX);
        if (v < ACC_QMIN)
            return q_t'(ACC_QMIN);
        return q_t'(v);
    endfunction

    // loop bounds (last index) of each phase
    function automatic lim_t lim_at(input phase_t ph);
        lim_t l;
        l = '{ni: 2'd0, nj: 2'd0, nk: 2'd0};
        case (ph)
            PH_TMP, PH_IINV:           l = '{ni: 2'd2, nj: 2'd2, nk: 2'd2};
            PH_W:                      l = '{ni: 2'd2, nj: 2'd0, nk: 2'd2};
            PH_NW, PH_VEL:             l = '{ni: 2'd2, nj: 2'd0, nk: 2'd0};
            PH_UPD, PH_D, PH_RUP:      l = '{ni: 2'd2, nj: 2'd2, nk: 2'd1};
            PH_SQ_A, PH_SQ_B, PH_SQ_C: l = '{ni: 2'd0, nj: 2'd0, nk: 2'd2};
            PH_DV_A, PH_DV_B, PH_DV_C: l = '{ni: 2'd2, nj: 2'd0, nk: 2'd0};
            PH_CR_A, PH_CR_B:          l = '{ni: 2'd2, nj: 2'd0, nk: 2'd1};
            default:                   l = '{ni: 2'd0, nj: 2'd0, nk: 2'd0};
        endcase
        return l;
    endfunction

    // micro-operation for a phase and loop position
    function automatic uop_t uop_at(input phase_t ph, input logic [1:0] i,
                                    input logic [1:0] j, input logic [1:0] k);
        uop_t       u;
        logic [1:0] i1;
        logic [1:0] i2;
        addr_t      sb;
        addr_t      mb;
        addr_t      ab;
        addr_t      bb;
        i1 = mod3p1(i);
        i2 = mod3p2(i);
        u  = '{kind: UK_MAC, ra: A_R, rb: A_R, dst: A_R};
        sb = A_L;
        mb = A_TQ;
        ab = A_R;
        bb = A_R;
        case (i)
            2'd1:    begin sb = A_P; mb = A_F;   end
            2'd2:    begin sb = A_X; mb = A_VEL; end
            default: begin sb = A_L; mb = A_TQ;  end
        endcase
        if (ph == PH_CR_A)
            ab = A_R + 6'd6;
        else
            bb = A_R + 6'd3;
        case (ph)
            PH_TMP:
            begin
                u.ra  = A_R + ix3(i, k);
                u.rb  = ib_addr(k, j);
                u.dst = A_TMP + ix3(i, j);
            end
            PH_IINV:
            begin
                u.ra  = A_TMP + ix3(i, k);
                u.rb  = A_R + ix3(j, k);
                u.dst = A_IINV + ix3(i, j);
            end
            PH_W:
            begin
                u.ra  = A_IINV + ix3(i, k);
                u.rb  = A_L + addr_t'(k);
                u.dst = A_W + addr_t'(i);
            end
            PH_NW:
            begin
                u.kind = UK_SUB;
                u.ra   = A_W + addr_t'(i);
                u.dst  = A_NW + addr_t'(i);
            end
            PH_VEL:
            begin
                u.ra  = A_MINV;
                u.rb  = A_P + addr_t'(i);
                u.dst = A_VEL + addr_t'(i);
            end
            PH_UPD:
            begin
                u.kind = (k == 2'd0) ? UK_ADD : UK_MAC;
                u.ra   = (k == 2'd0) ? sb + addr_t'(j) : mb + addr_t'(j);
                u.rb   = A_DT;
                u.dst  = sb + addr_t'(j);
            end
            PH_D:
            begin
                u.ra  = (k == 2'd0) ? A_NW + addr_t'(i2) : A_W + addr_t'(i1);
                u.rb  = (k == 2'd0) ? A_R + ix3(i1, j) : A_R + ix3(i2, j);
                u.dst = A_TMP + ix3(i, j);
            end
            PH_RUP:
            begin
                u.kind = (k == 2'd0) ? UK_ADD : UK_MAC;
                u.ra   = (k == 2'd0) ? A_R + ix3(i, j) : A_TMP + ix3(i, j);
                u.rb   = A_DT;
                u.dst  = A_R + ix3(i, j);
            end
            PH_SQ_A:
            begin
                u.kind = UK_SQR;
                u.ra   = A_R + addr_t'(k);
                u.rb   = A_R + addr_t'(k);
            end
            PH_SQ_B, PH_SQ_C:
            begin
                u.kind = UK_SQR;
                u.ra   = A_T3 + addr_t'(k);
                u.rb   = A_T3 + addr_t'(k);
            end
            PH_RT_A, PH_RT_B, PH_RT_C:
            begin
                u.kind = UK_ROOT;
            end
            PH_DV_A:
            begin
                u.kind = UK_DIV;
                u.ra   = A_R + addr_t'(i);
                u.dst  = A_R + addr_t'(i);
            end
            PH_DV_B:
            begin
                u.kind = UK_DIV;
                u.ra   = A_T3 + addr_t'(i);
                u.dst  = A_R + 6'd3 + addr_t'(i);
            end
            PH_DV_C:
            begin
                u.kind = UK_DIV;
                u.ra   = A_T3 + addr_t'(i);
                u.dst  = A_R + 6'd6 + addr_t'(i);
            end
            PH_CR_A, PH_CR_B:
            begin
                u.kind = (k == 2'd0) ? UK_MAC : UK_MSB;
                u.ra   = (k == 2'd0) ? ab + addr_t'(i1) : ab + addr_t'(i2);
                u.rb   = (k == 2'd0) ? bb + addr_t'(i2) : bb + addr_t'(i1);
                u.dst  = A_T3 + addr_t'(i);
            end
            default:
            begin
                u = '{kind: UK_MAC, ra: A_R, rb: A_R, dst: A_R};
            end
        endcase
        return u;
    endfunction

endpackage

[rtl/core/rbe_if.sv]
interface rbe_in_if;
    logic          valid;
    logic          ready;
    rbe_pkg::q_t   force_x;
    rbe_pkg::q_t   force_y;
    rbe_pkg::q_t   force_z;
    rbe_pkg::q_t   torque_x;
    rbe_pkg::q_t   torque_y;
    rbe_pkg::q_t   torque_z;
    rbe_pkg::dt_t  time_step;

    modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    time_step, input ready);
    modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    time_step, output ready);
endinterface

interface rbe_out_if;
    logic        valid;
    logic        ready;
    rbe_pkg::q_t pos_x;
    rbe_pkg::q_t pos_y;
    rbe_pkg::q_t pos_z;
    rbe_pkg::q_t rot_00;
    rbe_pkg::q_t rot_01;
    rbe_pkg::q_t rot_02;
    rbe_pkg::q_t rot_10;
    rbe_pkg::q_t rot_11;
    rbe_pkg::q_t rot_12;
    rbe_pkg::q_t rot_20;
    rbe_pkg::q_t rot_21;
    rbe_pkg::q_t rot_22;

    modport source (output valid, pos_x, pos_y, pos_z, rot_00, rot_01, rot_02, rot_10,
                    rot_11, rot_12, rot_20, rot_21, rot_22, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, rot_00, rot_01, rot_02, rot_10,
                    rot_11, rot_12, rot_20, rot_21, rot_22, output ready);
endinterface

[rtl/core/rbe_nrm.sv]
module rbe_nrm (
    input  logic              clk,
    input  logic              rst_n,
    input  rbe_pkg::nrm_req_t req,
    input  logic [63:0]       root_val,
    input  rbe_pkg::q_t       div_val,
    output rbe_pkg::nrm_sts_t sts
);
    import rbe_pkg::*;

    nrm_st_t     ns_reg;
    nrm_st_t     ns_next;
    logic [5:0]  it_reg;
    logic [5:0]  it_next;
    logic        done_reg;
    logic        done_next;
    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [31:0] n_reg;
    logic [31:0] rem_reg;
    logic [47:0] quo_reg;
    logic        neg_reg;
    logic        zero_reg;
    q_t          val_reg;

    logic [63:0] rb_sum;
    logic        root_ge;
    logic [63:0] x_step;
    logic [63:0] r_step;
    logic [32:0] rem_sh;
    logic        div_ge;
    logic [32:0] rem_sub;
    logic [47:0] quo_step;
    logic [32:0] sx;
    logic [32:0] mag33;
    logic [47:0] dividend;
    q_t          div_res;

    // one root bit per cycle
    always_comb
    begin
        rb_sum  = r_reg + bit_reg;
        root_ge = (x_reg >= rb_sum);
        x_step  = root_ge ? x_reg - rb_sum : x_reg;
        r_step  = root_ge ? (r_reg >> 1) + bit_reg : r_reg >> 1;
    end

    // one quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[47]};
        div_ge   = (rem_sh >= {1'b0, n_reg});
        rem_sub  = div_ge ? rem_sh - {1'b0, n_reg} : rem_sh;
        quo_step = {quo_reg[46:0], div_ge};
        sx       = {div_val[31], div_val};
        mag33    = div_val[31] ? (~sx + 33'd1) : sx;
        dividend = {mag33[31:0], 16'd0} + 48'(n_reg >> 1);
    end

    // saturate and sign the finished quotient, zero for a zero divisor
    always_comb
    begin
        if (zero_reg)
            div_res = '0;
        else if (!neg_reg)
            div_res = (quo_step > 48'h0000_7FFF_FFFF) ? q_t'(ACC_QMAX) : q_t'(quo_step[31:0]);
        else if (quo_step >= 48'h0000_8000_0000)
            div_res = q_t'(ACC_QMIN);
        else
            div_res = q_t'(~quo_step[31:0] + 32'd1);
    end

    // sequencer
    always_comb
    begin
        ns_next   = ns_reg;
        it_next   = it_reg;
        done_next = 1'b0;
        case (ns_reg)
            NS_IDLE:
            begin
                it_next = '0;
                if (req.root_go)
                    ns_next = NS_ROOT;
                else if (req.div_go)
                    ns_next = NS_DIV;
            end
            NS_ROOT:
            begin
                it_next = it_reg + 6'd1;
                if (it_reg == 6'd31)
                begin
                    ns_next   = NS_IDLE;
                    done_next = 1'b1;
                end
            end
            NS_DIV:
            begin
                it_next = it_reg + 6'd1;
                if (it_reg == 6'd47)
                begin
                    ns_next   = NS_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                ns_next = NS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_reg   <= NS_IDLE;
            it_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ns_reg   <= ns_next;
            it_reg   <= it_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (ns_reg)
            NS_IDLE:
            begin
                if (req.root_go)
                begin
                    x_reg   <= root_val;
                    r_reg   <= '0;
                    bit_reg <= 64'h4000_0000_0000_0000;
                end
                else if (req.div_go)
                begin
                    quo_reg  <= dividend;
                    rem_reg  <= '0;
                    neg_reg  <= div_val[31];
                    zero_reg <= (n_reg == '0);
                end
            end
            NS_ROOT:
            begin
                x_reg   <= x_step;
                r_reg   <= r_step;
                bit_reg <= bit_reg >> 2;
                if (it_reg == 6'd31)
                    n_reg <= r_step[31:0];
            end
            NS_DIV:
            begin
                rem_reg <= rem_sub[31:0];
                quo_reg <= quo_step;
                if (it_reg == 6'd47)
                    val_reg <= div_res;
            end
            default:
            begin
                val_reg <= val_reg;
            end
        endcase
    end

    assign sts.done  = done_reg;
    assign sts.value = val_reg;

endmodule

[rtl/core/rigid_body_euler_step.sv]
// channel   direction  transfer payload
// req       in         force_x/y/z, torque_x/y/z, time_step
// rsp       out        pos_x/y/z, rot_00 .. rot_22
// apb       in/out     inertia_inv_xx .. inertia_inv_yz, mass_inverse
//
// rsp becomes valid in the same cycle that req is ready again, after the step's work:
// 144 arithmetic operations in a datapath with a single shared multiplier, three
// bit-serial square roots and nine bit-serial divides, plus the load of the
// operands, a wait and the unload of the results.
// after reset an initial pass writes the initial state into scratch memory; req is
// not ready meanwhile. a finished result waits in the output register while the next
// step is taken; that step holds before its unload until rsp has been transferred.
module rigid_body_euler_step (
    input  logic                    clk,
    input  logic                    rst_n,
    rbe_in_if.sink                  req,
    rbe_out_if.source               rsp,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [rbe_pkg::PAW-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import rbe_pkg::*;

    st_t        state_reg;
    st_t        state_next;
    phase_t     ph_reg;
    phase_t     ph_next;
    logic [1:0] i_reg;
    logic [1:0] i_next;
    logic [1:0] j_reg;
    logic [1:0] j_next;
    logic [1:0] k_reg;
    logic [1:0] k_next;
    cnt_t       cnt_reg;
    cnt_t       cnt_next;
    acc_t       acc_reg;
    acc_t       acc_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    logic signed [63:0] prod_reg;
    q_t                 rda_reg;
    q_t                 rdb_reg;
    logic [31:0]        mem [64];

    q_t    fx_reg, fy_reg, fz_reg, tx_reg, ty_reg, tz_reg;
    dt_t   dt_reg;
    q_t    ixx_reg, iyy_reg, izz_reg, ixy_reg, ixz_reg, iyz_reg;
    minv_t minv_reg;
    q_t    out_reg [OUT_N];

    uop_t       u;
    lim_t       lm;
    acc_t       term;
    acc_t       acc_sum;
    logic       mem_we;
    addr_t      mem_wa;
    q_t         mem_wd;
    addr_t      mem_ra;
    addr_t      mem_rb;
    logic       out_ld;
    logic       adv;
    q_t         load_val;
    logic       cfg_wr;
    nrm_req_t   nrm_req;
    nrm_sts_t   nrm_sts;
    cnt_t       cnt_m1;
    logic [3:0] out_idx;

    rbe_nrm u_nrm (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (nrm_req),
        .root_val (acc_reg[63:0]),
        .div_val  (rda_reg),
        .sts      (nrm_sts)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ixx_reg  <= QONE;
            iyy_reg  <= QONE;
            izz_reg  <= QONE;
            ixy_reg  <= '0;
            ixz_reg  <= '0;
            iyz_reg  <= '0;
            minv_reg <= minv_t'(QONE);
        end
        else if (cfg_wr)
        begin
            case (cfg_idx_t'(paddr[4:2]))
                CFG_IXX:  ixx_reg  <= q_t'(pwdata);
                CFG_IYY:  iyy_reg  <= q_t'(pwdata);
                CFG_IZZ:  izz_reg  <= q_t'(pwdata);
                CFG_IXY:  ixy_reg  <= q_t'(pwdata);
                CFG_IXZ:  ixz_reg  <= q_t'(pwdata);
                CFG_IYZ:  iyz_reg  <= q_t'(pwdata);
                CFG_MINV: minv_reg <= pwdata[30:0];
                default:  minv_reg <= minv_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx_t'(paddr[4:2]))
            CFG_IXX:  prdata = ixx_reg;
            CFG_IYY:  prdata = iyy_reg;
            CFG_IZZ:  prdata = izz_reg;
            CFG_IXY:  prdata = ixy_reg;
            CFG_IXZ:  prdata = ixz_reg;
            CFG_IYZ:  prdata = iyz_reg;
            CFG_MINV: prdata = {1'b0, minv_reg};
            default:  prdata = '0;
        endcase
    end

    // input capture on transfer
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            fx_reg <= req.force_x;
            fy_reg <= req.force_y;
            fz_reg <= req.force_z;
            tx_reg <= req.torque_x;
            ty_reg <= req.torque_y;
            tz_reg <= req.torque_z;
            dt_reg <= req.time_step;
        end
    end

    // operand load into scratch memory
    always_comb
    begin
        case (cnt_reg)
            5'd0:    load_val = fx_reg;
            5'd1:    load_val = fy_reg;
            5'd2:    load_val = fz_reg;
            5'd3:    load_val = tx_reg;
            5'd4:    load_val = ty_reg;
            5'd5:    load_val = tz_reg;
            5'd6:    load_val = q_t'({15'd0, dt_reg});
            5'd7:    load_val = ixx_reg;
            5'd8:    load_val = iyy_reg;
            5'd9:    load_val = izz_reg;
            5'd10:   load_val = ixy_reg;
            5'd11:   load_val = ixz_reg;
            5'd12:   load_val = iyz_reg;
            5'd13:   load_val = q_t'({1'b0, minv_reg});
            default: load_val = '0;
        endcase
    end

    // scratch memory, registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rda_reg <= mem[mem_ra];
        rdb_reg <= mem[mem_rb];
    end

    // shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= rda_reg * rdb_reg;
    end

    // accumulate term
    always_comb
    begin
        u  = uop_at(ph_reg, i_reg, j_reg, k_reg);
        lm = lim_at(ph_reg);
        case (u.kind)
            UK_MAC, UK_MSB: term = (acc_t'(prod_reg) + ACC_HALF) >>> 16;
            UK_SQR:         term = acc_t'(prod_reg);
            UK_ADD, UK_SUB: term = sext_q(rda_reg);
            default:        term = '0;
        endcase
        if (u.kind == UK_MSB || u.kind == UK_SUB)
            acc_sum = acc_reg - term;
        else
            acc_sum = acc_reg + term;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        mem_we         = 1'b0;
        mem_wa         = u.dst;
        mem_wd         = sat32(acc_sum);
        mem_ra         = u.ra;
        mem_rb         = u.rb;
        out_ld         = 1'b0;
        adv            = 1'b0;
        nrm_req        = '0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we   = 1'b1;
                mem_wa   = addr_t'(cnt_reg);
                mem_wd   = (cnt_reg == 5'd0 || cnt_reg == 5'd4 || cnt_reg == 5'd8) ? QONE : '0;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == cnt_t'(INIT_N - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                mem_we   = 1'b1;
                mem_wa   = A_F + addr_t'(cnt_reg);
                mem_wd   = load_val;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == cnt_t'(LOAD_N - 1))
                begin
                    cnt_next   = '0;
                    ph_next    = PH_TMP;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EX;
            end
            ST_EX:
            begin
                if (u.kind == UK_ROOT)
                begin
                    nrm_req.root_go = 1'b1;
                    acc_next        = '0;
                    state_next      = ST_ROOT;
                end
                else if (u.kind == UK_DIV)
                begin
                    nrm_req.div_go = 1'b1;
                    state_next     = ST_DIV;
                end
                else
                    state_next = ST_AC;
            end
            ST_AC:
            begin
                adv = 1'b1;
                if (u.kind != UK_SQR && k_reg == lm.nk)
                begin
                    mem_we   = 1'b1;
                    acc_next = '0;
                end
                else
                    acc_next = acc_sum;
            end
            ST_ROOT:
            begin
                adv = nrm_sts.done;
            end
            ST_DIV:
            begin
                if (nrm_sts.done)
                begin
                    mem_we = 1'b1;
                    mem_wd = nrm_sts.value;
                    adv    = 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (!out_valid_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_UNLD;
                end
            end
            ST_UNLD:
            begin
                mem_ra   = (cnt_reg < 5'd3) ? A_X + addr_t'(cnt_reg)
                                            : A_R + addr_t'(cnt_reg - 5'd3);
                out_ld   = (cnt_reg != '0);
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == cnt_t'(OUT_N))
                begin
                    cnt_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // step the loop counters and phase
        if (adv)
        begin
            state_next = ST_RD;
            if (k_reg != lm.nk)
                k_next = k_reg + 2'd1;
            else
            begin
                k_next = '0;
                if (j_reg != lm.nj)
                    j_next = j_reg + 2'd1;
                else
                begin
                    j_next = '0;
                    if (i_reg != lm.ni)
                        i_next = i_reg + 2'd1;
                    else
                    begin
                        i_next = '0;
                        if (ph_reg == PH_DV_C)
                            state_next = ST_WAIT;
                        else
                            ph_next = phase_t'(ph_reg + 5'd1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            ph_reg        <= PH_TMP;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register, filled during unload
    assign cnt_m1  = cnt_reg - 5'd1;
    assign out_idx = cnt_m1[3:0];

    always_ff @(posedge clk)
    begin
        if (out_ld)
            out_reg[out_idx] <= rda_reg;
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.pos_x  = out_reg[0];
    assign rsp.pos_y  = out_reg[1];
    assign rsp.pos_z  = out_reg[2];
    assign rsp.rot_00 = out_reg[3];
    assign rsp.rot_01 = out_reg[4];
    assign rsp.rot_02 = out_reg[5];
    assign rsp.rot_10 = out_reg[6];
    assign rsp.rot_11 = out_reg[7];
    assign rsp.rot_12 = out_reg[8];
    assign rsp.rot_20 = out_reg[9];
    assign rsp.rot_21 = out_reg[10];
    assign rsp.rot_22 = out_reg[11];

endmodule

[rtl/core/rbe_chk.sv]
module rbe_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input rbe_pkg::q_t pos_x,
    input rbe_pkg::q_t rot_00
);
    import rbe_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload (pos_x and rot_00 are checked)
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(pos_x) && $stable(rot_00)))
        else $error("result payload changed while stalled");

    // one step at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second step taken while busy");

    // a result never follows a transfer at once
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result too soon after transfer");

endmodule

bind rigid_body_euler_step rbe_chk u_rbe_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .pos_x     (rsp.pos_x),
    .rot_00    (rsp.rot_00)
);

[verif/tb_rigid_body_euler_step.sv]
`timescale 1ns / 1ps

module tb_rigid_body_euler_step;
    import rbe_pkg::*;

    typedef struct {
        q_t   frc[3];
        q_t   trq[3];
        dt_t  dt;
    } step_in_t;

    typedef struct {
        q_t pos[3];
        q_t rot[9];
    } body_pose_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PAW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    rbe_in_if  req ();
    rbe_out_if rsp ();

    rigid_body_euler_step dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and configuration copy
    longint m_pos[3];
    longint m_mom[3];
    longint m_ang[3];
    longint m_rot[9];
    longint m_ib[6];
    longint m_minv;

    step_in_t   pending_steps[$];
    body_pose_t expected_poses[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_sender;
    int  hold_base;
    int  error_count;
    int  quiet_cycles;
    int  sent_count;
    int  seen_count;

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint sat_q(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // rounded q16.16 product, half up
    function automatic longint qmul(input longint a, input longint b);
        return (a * b + 32768) >>> 16;
    endfunction

    function automatic longint fsqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic unit_vec(input longint v[3], output longint o[3]);
        longint unsigned s;
        longint unsigned n;
        longint unsigned mag;
        longint unsigned q;
        s = 0;
        for (int i = 0; i < 3; i++)
            s = s + longint'(v[i] * v[i]);
        n = fsqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            if (n == 0)
                o[i] = 0;
            else
            begin
                mag = (v[i] < 0 ? -v[i] : v[i]) * 64'd65536;
                q = (mag + n / 2) / n;
                if (q > 64'd2147483648)
                    q = 64'd2147483648;
                o[i] = sat_q(v[i] < 0 ? -longint'(q) : longint'(q));
            end
        end
    endtask

    task automatic cross_vec(input longint a[3], input longint b[3], output longint o[3]);
        o[0] = sat_q(qmul(a[1], b[2]) - qmul(a[2], b[1]));
        o[1] = sat_q(qmul(a[2], b[0]) - qmul(a[0], b[2]));
        o[2] = sat_q(qmul(a[0], b[1]) - qmul(a[1], b[0]));
    endtask

    task automatic mat_mul(input longint a[9], input longint b[9], output longint o[9]);
        longint s;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                s = 0;
                for (int k = 0; k < 3; k++)
                    s += qmul(a[i*3+k], b[k*3+j]);
                o[i*3+j] = sat_q(s);
            end
    endtask

    // advance the body by one step and return the new pose
    task automatic integrate_step(input step_in_t st, output body_pose_t pose);
        longint ib[9];
        longint rt[9];
        longint tmp[9];
        longint iinv[9];
        longint sk[9];
        longint d[9];
        longint w[3];
        longint vel[3];
        longint r0[3];
        longint r1[3];
        longint r2[3];
        longint t3[3];
        longint row[3];
        longint dt;
        longint s;
        dt = st.dt;
        ib = '{m_ib[0], m_ib[3], m_ib[4], m_ib[3], m_ib[1], m_ib[5],
               m_ib[4], m_ib[5], m_ib[2]};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                rt[i*3+j] = m_rot[j*3+i];
        mat_mul(m_rot, ib, tmp);
        mat_mul(tmp, rt, iinv);
        for (int i = 0; i < 3; i++)
        begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += qmul(iinv[i*3+j], m_ang[j]);
            w[i] = sat_q(s);
            vel[i] = sat_q(qmul(m_minv, m_mom[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            m_ang[i] = sat_q(m_ang[i] + qmul(st.trq[i], dt));
            m_mom[i] = sat_q(m_mom[i] + qmul(st.frc[i], dt));
            m_pos[i] = sat_q(m_pos[i] + qmul(vel[i], dt));
        end
        sk = '{0, sat_q(-w[2]), w[1], w[2], 0, sat_q(-w[0]), sat_q(-w[1]), w[0], 0};
        mat_mul(sk, m_rot, d);
        for (int i = 0; i < 9; i++)
            m_rot[i] = sat_q(m_rot[i] + qmul(d[i], dt));
        row = '{m_rot[0], m_rot[1], m_rot[2]};
        unit_vec(row, r0);
        row = '{m_rot[6], m_rot[7], m_rot[8]};
        cross_vec(row, r0, t3);
        unit_vec(t3, r1);
        cross_vec(r0, r1, t3);
        unit_vec(t3, r2);
        for (int i = 0; i < 3; i++)
        begin
            m_rot[i] = r0[i];
            m_rot[3+i] = r1[i];
            m_rot[6+i] = r2[i];
            pose.pos[i] = q_t'(m_pos[i]);
        end
        for (int i = 0; i < 9; i++)
            pose.rot[i] = q_t'(m_rot[i]);
    endtask

    // driver: offer pending steps, predict on each transfer
    always @(posedge clk or negedge rst_n)
    begin
        body_pose_t pose;
        step_in_t   st;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                st = pending_steps.pop_front();
                integrate_step(st, pose);
                expected_poses.push_back(pose);
                sent_count++;
            end
            if ((!req.valid || req.ready) )
            begin
                if (pending_steps.size() > 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    st = pending_steps[0];
                    req.valid     <= 1'b1;
                    req.force_x   <= st.frc[0];
                    req.force_y   <= st.frc[1];
                    req.force_z   <= st.frc[2];
                    req.torque_x  <= st.trq[0];
                    req.torque_y  <= st.trq[1];
                    req.torque_z  <= st.trq[2];
                    req.time_step <= st.dt;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        body_pose_t exp_p;
        q_t got[12];
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.rot_00, rsp.rot_01,
                        rsp.rot_02, rsp.rot_10, rsp.rot_11, rsp.rot_12, rsp.rot_20,
                        rsp.rot_21, rsp.rot_22};
                seen_count++;
                if (expected_poses.size() == 0)
                begin
                    $display("%0t unexpected result pos_x=%0d", $time, got[0]);
                    error_count++;
                end
                else
                begin
                    exp_p = expected_poses.pop_front();
                    for (int i = 0; i < 12; i++)
                        if (got[i] !== (i < 3 ? exp_p.pos[i] : exp_p.rot[i-3]))
                        begin
                            $display("%0t field %0d expected %0d actual %0d", $time, i,
                                     (i < 3 ? exp_p.pos[i] : exp_p.rot[i-3]), got[i]);
                            error_count++;
                        end
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no transfer and no configuration access
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic reg_write(input cfg_idx_t idx, input logic [31:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAW'(4 * int'(idx));
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_MINV)
            m_minv = v[30:0];
        else
            m_ib[int'(idx)] = longint'($signed(v));
    endtask

    task automatic drain;
        wait (pending_steps.size() == 0 && expected_poses.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic q_t rnd_q(input int mode);
        case (mode)
            0: return q_t'($urandom);
            1: return q_t'($signed($urandom_range(131072)) - 65536);
            default: return q_t'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    task automatic add_step(input q_t f0, input q_t f1, input q_t f2, input q_t t0,
                            input q_t t1, input q_t t2, input dt_t dt);
        step_in_t st;
        st.frc = '{f0, f1, f2};
        st.trq = '{t0, t1, t2};
        st.dt = dt;
        pending_steps.push_back(st);
    endtask

    task automatic add_random(input int n, input int mode);
        int m;
        dt_t dt;
        for (int i = 0; i < n; i++)
        begin
            m = ($urandom_range(9) == 0) ? 0 : mode;
            case ($urandom_range(5))
                0: dt = dt_t'($urandom);
                1: dt = 17'd65536;
                default: dt = dt_t'($urandom_range(4096));
            endcase
            add_step(rnd_q(m), rnd_q(m), rnd_q(m), rnd_q(m), rnd_q(m), rnd_q(m), dt);
        end
    endtask

    task automatic random_inertia(input int mode);
        reg_write(CFG_IXX, rnd_q(mode));
        reg_write(CFG_IYY, rnd_q(mode));
        reg_write(CFG_IZZ, rnd_q(mode));
        reg_write(CFG_IXY, rnd_q(mode));
        reg_write(CFG_IXZ, rnd_q(mode));
        reg_write(CFG_IYZ, rnd_q(mode));
        reg_write(CFG_MINV, $urandom & 32'h7fffffff);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req.valid = 1'b0;
        req.force_x = '0;
        req.force_y = '0;
        req.force_z = '0;
        req.torque_x = '0;
        req.torque_y = '0;
        req.torque_z = '0;
        req.time_step = '0;
        rsp.ready = 1'b0;
        hold_sender = 1'b0;
        hold_base = 0;
        error_count = 0;
        quiet_cycles = 0;
        sent_count = 0;
        seen_count = 0;
        send_idle_pct = 29;
        recv_idle_pct = 78;
        for (int i = 0; i < 3; i++)
        begin
            m_pos[i] = 0;
            m_mom[i] = 0;
            m_ang[i] = 0;
        end
        for (int i = 0; i < 9; i++)
            m_rot[i] = (i % 4 == 0) ? 65536 : 0;
        m_ib = '{65536, 65536, 65536, 0, 0, 0};
        m_minv = 65536;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (25) @(posedge clk);

        // directed: zero step, extremes, large dt, saturation, zero rows
        add_step(0, 0, 0, 0, 0, 0, 0);
        add_step(32'sh7fffffff, 32'sh80000000, 32'sh00010000, 32'sh00020000,
                 32'shfffe0000, 32'sh00008000, 17'd65536);
        add_step(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh7fffffff, 17'h1ffff);
        add_step(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh80000000, 32'sh80000000, 17'h1ffff);
        add_step(32'sh00010000, 0, 0, 0, 0, 32'sh00100000, 17'd1);
        add_step(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff,
                 32'shffff0000, 32'sh00000001, 17'h0aaaa);
        drain();

        // sender holds, once steps are in flight, until all expected results are in
        add_random(6, 2);
        hold_base = sent_count;
        wait (sent_count >= hold_base + 2);
        hold_sender = 1'b1;
        wait (expected_poses.size() == 0);
        repeat (5) @(posedge clk);
        hold_sender = 1'b0;
        drain();

        // extreme configuration then zero inverse mass
        reg_write(CFG_IXX, 32'h7fffffff);
        reg_write(CFG_IYY, 32'h80000000);
        reg_write(CFG_IZZ, 32'h00000000);
        reg_write(CFG_IXY, 32'h7fffffff);
        reg_write(CFG_IXZ, 32'h80000000);
        reg_write(CFG_IYZ, 32'hffffffff);
        reg_write(CFG_MINV, 32'h7fffffff);
        add_random(8, 1);
        drain();
        reg_write(CFG_MINV, 32'h00000000);
        add_random(4, 0);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 78 : 0;
            recv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 29 : 0;
            for (int blk = 0; blk < 6; blk++)
            begin
                random_inertia(blk % 3 == 0 ? 0 : 1);
                add_random(75, 1 + (blk % 2));
                drain();
            end
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
